>>> hdl/sha1s_pkg.sv
// Shared types and constants for the SHA-1 stream hasher.
// Used by the front end, the word queue, the round core and the top level.
package sha1s_pkg;

   localparam int WORD_W      = 32;
   localparam int COUNT_W     = 61;
   localparam int ROUND_W     = 7;
   localparam int SCHED_WORDS = 16;
   localparam int ROUNDS      = 80;

   localparam logic [WORD_W-1:0] H0_INIT = 32'h67452301;
   localparam logic [WORD_W-1:0] H1_INIT = 32'hefcdab89;
   localparam logic [WORD_W-1:0] H2_INIT = 32'h98badcfe;
   localparam logic [WORD_W-1:0] H3_INIT = 32'h10325476;
   localparam logic [WORD_W-1:0] H4_INIT = 32'hc3d2e1f0;

   localparam logic [WORD_W-1:0] K_CH  = 32'h5a827999;
   localparam logic [WORD_W-1:0] K_P1  = 32'h6ed9eba1;
   localparam logic [WORD_W-1:0] K_MAJ = 32'h8f1bbcdc;
   localparam logic [WORD_W-1:0] K_P2  = 32'hca62c1d6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // One big-endian message word on its way to the core; is_final marks
   // the last word of the last block of a message.
   typedef struct packed {
      logic              is_final;
      logic [WORD_W-1:0] word;
   } word_entry_type;

endpackage

>>> hdl/sha1s_front.sv
// Front end: accepts byte items, packs them into words, appends padding and length.
// Depends on sha1s_pkg; feeds sha1s_queue.
module sha1s_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_has_byte,
   input  logic                    req_last,
   input  logic                    q_full,
   output logic                    q_push,
   output sha1s_pkg::word_entry_type q_push_entry
);
   import sha1s_pkg::*;

   typedef enum logic [4:0] {
      ST_ACCEPT   = 5'b00001,
      ST_PAD_HEAD = 5'b00010,
      ST_PAD_ZERO = 5'b00100,
      ST_LEN_HI   = 5'b01000,
      ST_LEN_LO   = 5'b10000
   } front_state_type;

   localparam logic [3:0] LEN_HI_SLOT = 4'd14;
   localparam logic [3:0] LAST_ZERO_SLOT = LEN_HI_SLOT - 4'd1;

   front_state_type    state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [23:0]        acc_ff, acc_in;
   logic [3:0]         pad_idx_ff, pad_idx_in;
   logic               accept;

   assign req_stall = (state_ff != ST_ACCEPT) || q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      pad_idx_in   = pad_idx_ff;
      q_push       = 1'b0;
      q_push_entry = '{is_final: 1'b0, word: '0};
      unique case (state_ff)
         ST_ACCEPT: begin
            if (accept) begin
               if (req_has_byte) begin
                  acc_in   = {acc_ff[15:0], req_data_byte};
                  count_in = count_ff + COUNT_W'(1);
                  if (count_ff[1:0] == 2'd3) begin
                     q_push            = 1'b1;
                     q_push_entry.word = {acc_ff, req_data_byte};
                  end
               end
               if (req_last) begin
                  state_in = ST_PAD_HEAD;
               end
            end
         end
         ST_PAD_HEAD: begin
            if (!q_full) begin
               q_push = 1'b1;
               case (count_ff[1:0])
                  2'd0: q_push_entry.word = {PAD_BYTE, 24'h0};
                  2'd1: q_push_entry.word = {acc_ff[7:0], PAD_BYTE, 16'h0};
                  2'd2: q_push_entry.word = {acc_ff[15:0], PAD_BYTE, 8'h0};
                  default: q_push_entry.word = {acc_ff, PAD_BYTE};
               endcase
               if (count_ff[5:2] == LAST_ZERO_SLOT) begin
                  state_in = ST_LEN_HI;
               end else begin
                  pad_idx_in = count_ff[5:2] + 4'd1;
                  state_in   = ST_PAD_ZERO;
               end
            end
         end
         ST_PAD_ZERO: begin
            if (!q_full) begin
               q_push = 1'b1;
               if (pad_idx_ff == LAST_ZERO_SLOT) begin
                  state_in = ST_LEN_HI;
               end else begin
                  pad_idx_in = pad_idx_ff + 4'd1;
               end
            end
         end
         ST_LEN_HI: begin
            if (!q_full) begin
               q_push            = 1'b1;
               q_push_entry.word = count_ff[60:29];
               state_in          = ST_LEN_LO;
            end
         end
         ST_LEN_LO: begin
            if (!q_full) begin
               q_push       = 1'b1;
               q_push_entry = '{is_final: 1'b1, word: {count_ff[28:0], 3'b000}};
               count_in     = '0;
               state_in     = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      pad_idx_ff <= pad_idx_in;
   end

endmodule

>>> hdl/sha1s_queue.sv
// Short word queue between the front end and the round core.
// Depends on sha1s_pkg for the entry type.
module sha1s_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sha1s_pkg::word_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      pop_valid,
   output sha1s_pkg::word_entry_type pop_entry
);
   import sha1s_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   word_entry_type   entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fill_ff;
   logic             do_push, do_pop;

   assign full      = (fill_ff == CNT_FULL);
   assign pop_valid = (fill_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_FULL)
      else $error("queue fill above depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("word pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !pop_valid |-> !pop)
      else $error("word popped from an empty queue");

endmodule

>>> hdl/sha1s_core.sv
// Round core: 80 SHA-1 rounds per block over a rolling 16-word schedule,
// chain update and digest register. Depends on sha1s_pkg; fed by sha1s_queue.
module sha1s_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  sha1s_pkg::word_entry_type q_entry,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [31:0]               rsp_digest_word_a,
   output logic [31:0]               rsp_digest_word_b,
   output logic [31:0]               rsp_digest_word_c,
   output logic [31:0]               rsp_digest_word_d,
   output logic [31:0]               rsp_digest_word_e
);
   import sha1s_pkg::*;

   localparam logic [ROUND_W-1:0] LOAD_END   = ROUND_W'(SCHED_WORDS);
   localparam logic [ROUND_W-1:0] LAST_LOAD  = ROUND_W'(SCHED_WORDS - 1);
   localparam logic [ROUND_W-1:0] FINISH     = ROUND_W'(ROUNDS);
   localparam logic [ROUND_W-1:0] PHASE1_END = ROUND_W'(20);
   localparam logic [ROUND_W-1:0] PHASE2_END = ROUND_W'(40);
   localparam logic [ROUND_W-1:0] PHASE3_END = ROUND_W'(60);

   function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] v);
      return {v[WORD_W-2:0], v[WORD_W-1]};
   endfunction

   function automatic logic [WORD_W-1:0] rotl5(input logic [WORD_W-1:0] v);
      return {v[WORD_W-6:0], v[WORD_W-1:WORD_W-5]};
   endfunction

   function automatic logic [WORD_W-1:0] rotl30(input logic [WORD_W-1:0] v);
      return {v[1:0], v[WORD_W-1:2]};
   endfunction

   logic [ROUND_W-1:0] round_ff;
   logic [WORD_W-1:0]  work_ff   [5];
   logic [WORD_W-1:0]  chain_ff  [5];
   logic [WORD_W-1:0]  window_ff [SCHED_WORDS];
   logic               final_blk_ff;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  digest_ff [5];

   logic [WORD_W-1:0]  init_val [5];
   logic [WORD_W-1:0]  sum_val  [5];
   logic [WORD_W-1:0]  w_sched, w_cur, f_val, k_val, t_val;
   logic               loading, rounding, finishing, rsp_free, step;

   assign init_val[0] = H0_INIT;
   assign init_val[1] = H1_INIT;
   assign init_val[2] = H2_INIT;
   assign init_val[3] = H3_INIT;
   assign init_val[4] = H4_INIT;

   assign loading   = (round_ff < LOAD_END);
   assign finishing = (round_ff == FINISH);
   assign rounding  = !finishing;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Load rounds wait for a word; the finish cycle of a final block waits
   // for the digest register.
   always_comb begin
      if (loading) begin
         step = q_valid;
      end else if (finishing) begin
         step = !final_blk_ff || rsp_free;
      end else begin
         step = 1'b1;
      end
   end

   assign q_pop = loading && q_valid;

   assign w_sched = rotl1(window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0]);
   assign w_cur   = loading ? q_entry.word : w_sched;

   always_comb begin
      if (round_ff < PHASE1_END) begin
         f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k_val = K_CH;
      end else if (round_ff < PHASE2_END) begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K_P1;
      end else if (round_ff < PHASE3_END) begin
         f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3])
               | (work_ff[2] & work_ff[3]);
         k_val = K_MAJ;
      end else begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K_P2;
      end
   end

   assign t_val = rotl5(work_ff[0]) + f_val + work_ff[4] + k_val + w_cur;

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         sum_val[i] = chain_ff[i] + work_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff     <= '0;
         final_blk_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= init_val[i];
            work_ff[i]  <= init_val[i];
         end
      end else begin
         // Raise on a final block finish, else drop once the digest is taken.
         if (step && finishing && final_blk_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (step && rounding) begin
            work_ff[0] <= t_val;
            work_ff[1] <= work_ff[0];
            work_ff[2] <= rotl30(work_ff[1]);
            work_ff[3] <= work_ff[2];
            work_ff[4] <= work_ff[3];
            round_ff   <= round_ff + ROUND_W'(1);
            if (round_ff == LAST_LOAD) begin
               final_blk_ff <= q_entry.is_final;
            end
         end
         if (step && finishing) begin
            round_ff <= '0;
            for (int i = 0; i < 5; i++) begin
               chain_ff[i] <= final_blk_ff ? init_val[i] : sum_val[i];
               work_ff[i]  <= final_blk_ff ? init_val[i] : sum_val[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && rounding) begin
         for (int i = 0; i < SCHED_WORDS - 1; i++) begin
            window_ff[i] <= window_ff[i + 1];
         end
         window_ff[SCHED_WORDS - 1] <= w_cur;
      end
      if (step && finishing && final_blk_ff) begin
         for (int i = 0; i < 5; i++) begin
            digest_ff[i] <= sum_val[i];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_digest_word_a = digest_ff[0];
   assign rsp_digest_word_b = digest_ff[1];
   assign rsp_digest_word_c = digest_ff[2];
   assign rsp_digest_word_d = digest_ff[3];
   assign rsp_digest_word_e = digest_ff[4];

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      round_ff <= FINISH)
      else $error("round counter past finish");
   a_digest_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(finishing) && $past(final_blk_ff))
      else $error("digest raised outside a final block finish");
   a_block_start: assert property (@(posedge clock) disable iff (reset)
      (round_ff == '0) |-> (work_ff[0] == chain_ff[0]) && (work_ff[4] == chain_ff[4]))
      else $error("working state differs from chain at block start");
   a_finish_empty_load: assert property (@(posedge clock) disable iff (reset)
      !loading |-> !q_pop)
      else $error("word taken outside the load rounds");

endmodule

>>> hdl/sha1_stream_hasher.sv
// SHA-1 stream hasher, top level. Takes at most one message byte per item on the
// req_ channel and returns the 160-bit digest as five words on the rsp_ channel
// after the item marked last. Timing: the front end accepts one item per cycle
// while it is not padding and the word queue has room. The round core compresses
// each 64-byte block in 80 rounds plus a chain update, but each of its first 16
// rounds needs a queued word, and the queue (QUEUE_DEPTH words, four by default)
// runs only 16 bytes ahead of it, so the other 48 bytes of a block arrive one per
// cycle while the core waits. For a long message the rate is thus set by byte
// intake during the load rounds plus the later rounds and chain update, which
// intake overlaps only by the queue depth. After the last item the front end
// queues 3 to 18 padding words, one per cycle while the queue has room, stalling
// req_ meanwhile, and the core finishes one or two more blocks before the digest
// appears. The next message may start as soon as the padding has been queued. A
// digest waiting on rsp_stall holds only the finish of the next message's final
// block.
// Depends on sha1s_pkg, sha1s_front, sha1s_queue and sha1s_core.
module sha1_stream_hasher #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word_a,
   output logic [31:0] rsp_digest_word_b,
   output logic [31:0] rsp_digest_word_c,
   output logic [31:0] rsp_digest_word_d,
   output logic [31:0] rsp_digest_word_e
);
   import sha1s_pkg::*;

   // Front to queue: packed message words, padding and length.
   logic           push, q_full;
   word_entry_type push_entry;

   // Queue to core: one word per load round.
   logic           pop, pop_valid;
   word_entry_type pop_entry;

   // Pack bytes, pad, and append the bit length.
   sha1s_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_has_byte  (req_has_byte),
      .req_last      (req_last),
      .q_full        (q_full),
      .q_push        (push),
      .q_push_entry  (push_entry)
   );

   // Decouple byte intake from the round loop.
   sha1s_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // Compress blocks, chain the hash, hold the digest until taken.
   sha1s_core u_core (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (pop_valid),
      .q_entry           (pop_entry),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_digest_word_a (rsp_digest_word_a),
      .rsp_digest_word_b (rsp_digest_word_b),
      .rsp_digest_word_c (rsp_digest_word_c),
      .rsp_digest_word_d (rsp_digest_word_d),
      .rsp_digest_word_e (rsp_digest_word_e)
   );

endmodule

>>> verif/tb_top.sv
// Testbench for sha1_stream_hasher: feeds byte-stream messages on req_ and checks
// every digest on rsp_ against a SHA-1 predictor kept inside this module.
// Depends only on the RTL of the hasher; needs no files or arguments.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 4;
   localparam int ITEM_TARGET   = 950;
   localparam int TAIL_ITEMS    = 150;
   localparam int LONG_HOLD     = 800;
   localparam int SETTLE_CYCLES = 400;
   localparam int CYCLE_LIMIT   = 500000;

   // SHA-1 initial chaining value, round constants and padding marker.
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam logic [31:0] IV_E = 32'hc3d2e1f0;
   localparam logic [31:0] RK_CHOOSE  = 32'h5a827999;
   localparam logic [31:0] RK_PARITY1 = 32'h6ed9eba1;
   localparam logic [31:0] RK_MAJ     = 32'h8f1bbcdc;
   localparam logic [31:0] RK_PARITY2 = 32'hca62c1d6;
   localparam logic [7:0]  PAD_MARK   = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } hash_item_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } digest_type;

   // Clock, reset and block ports; every input starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word_a;
   logic [31:0] rsp_digest_word_b;
   logic [31:0] rsp_digest_word_c;
   logic [31:0] rsp_digest_word_d;
   logic [31:0] rsp_digest_word_e;

   // Stimulus and checking bookkeeping.
   hash_item_type pending_items[$];
   digest_type    expected_digests[$];
   logic        req_fire = 1'b0;
   int          send_gap = 0;
   int          rcv_gap = 0;
   int          send_idle_pct = 0;
   int          rsp_idle_pct = 0;
   logic        hold_trigger = 1'b0;
   logic        hold_started = 1'b0;
   int          hold_count = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          queued_items = 0;

   // Predictor state: the partly filled 64-byte block, the chaining hash and
   // the running byte count of the current message.
   logic [7:0]  msg_block [64];
   logic [31:0] chain_words [5];
   logic [60:0] msg_bytes;

   always #(CLK_PERIOD / 2) clock = ~clock;

   sha1_stream_hasher dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_has_byte      (req_has_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_digest_word_a (rsp_digest_word_a),
      .rsp_digest_word_b (rsp_digest_word_b),
      .rsp_digest_word_c (rsp_digest_word_c),
      .rsp_digest_word_d (rsp_digest_word_d),
      .rsp_digest_word_e (rsp_digest_word_e)
   );

   //--------------------------------------------------------------------------
   // SHA-1 predictor
   //--------------------------------------------------------------------------
   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned k);
      return (v << k) | (v >> (32 - k));
   endfunction

   // Start a fresh message: reload the chaining value, clear the count.
   function automatic void restart_message();
      chain_words[0] = IV_A;
      chain_words[1] = IV_B;
      chain_words[2] = IV_C;
      chain_words[3] = IV_D;
      chain_words[4] = IV_E;
      msg_bytes = '0;
   endfunction

   // Run the 80 rounds over msg_block and fold the result into the chain.
   function automatic void compress_msg_block();
      logic [31:0] sched [16];
      logic [31:0] a, b, c, d, e, f, k, t;
      int i;
      int r;
      int slot;
      for (i = 0; i < 16; i++) begin
         sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      end
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (r = 0; r < 80; r++) begin
         slot = r % 16;
         // Roll the schedule window in place from round 16 on.
         if (r >= 16) begin
            sched[slot] = rotl(sched[(slot + 13) % 16] ^ sched[(slot + 8) % 16]
                               ^ sched[(slot + 2) % 16] ^ sched[slot], 1);
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = RK_CHOOSE;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = RK_PARITY1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = RK_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = RK_PARITY2;
         end
         t = rotl(a, 5) + f + e + k + sched[slot];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain_words[0] = chain_words[0] + a;
      chain_words[1] = chain_words[1] + b;
      chain_words[2] = chain_words[2] + c;
      chain_words[3] = chain_words[3] + d;
      chain_words[4] = chain_words[4] + e;
   endfunction

   // Take one accepted item; on last, pad, finish and queue the digest.
   function automatic void absorb_item(input hash_item_type it);
      int pos;
      int i;
      logic [63:0] bit_len;
      digest_type dg;
      if (it.has_byte) begin
         msg_block[msg_bytes[5:0]] = it.data_byte;
         msg_bytes = msg_bytes + 61'd1;
         if (msg_bytes[5:0] == 6'd0) begin
            compress_msg_block();
         end
      end
      if (it.last) begin
         pos = int'(msg_bytes[5:0]);
         msg_block[pos] = PAD_MARK;
         pos++;
         // No room for the length field: close this block and open another.
         if (pos > 56) begin
            while (pos < 64) begin
               msg_block[pos] = 8'h00;
               pos++;
            end
            compress_msg_block();
            pos = 0;
         end
         while (pos < 56) begin
            msg_block[pos] = 8'h00;
            pos++;
         end
         bit_len = {msg_bytes, 3'b000};
         for (i = 0; i < 8; i++) begin
            msg_block[56 + i] = bit_len[63 - 8*i -: 8];
         end
         compress_msg_block();
         dg.a = chain_words[0];
         dg.b = chain_words[1];
         dg.c = chain_words[2];
         dg.d = chain_words[3];
         dg.e = chain_words[4];
         expected_digests.push_back(dg);
         restart_message();
      end
   endfunction

   function automatic void check_word(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %08h, got %08h", $time, field, want, got);
      end
   endfunction

   //--------------------------------------------------------------------------
   // Driver: present the next pending item at the falling edge, hold it until
   // the handshake completes, and insert random idle bursts between items.
   //--------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            // Idle burst in progress: hold valid low.
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_items.size() != 0 && $urandom_range(99) < send_idle_pct) begin
            // Start a random idle burst, this one included.
            req_valid <= 1'b0;
            send_gap  <= $urandom_range(16);
         end else if (pending_items.size() != 0) begin
            req_valid     <= 1'b1;
            req_data_byte <= pending_items[0].data_byte;
            req_has_byte  <= pending_items[0].has_byte;
            req_last      <= pending_items[0].last;
            void'(pending_items.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   //--------------------------------------------------------------------------
   // Receiver: drive rsp_stall at the falling edge. A single long hold-off is
   // counted here so the block backs up and stalls its input; otherwise stall
   // in random bursts.
   //--------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_count > 0) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count - 1;
      end else if (hold_trigger && !hold_started) begin
         rsp_stall    <= 1'b1;
         hold_started <= 1'b1;
         hold_count   <= LONG_HOLD - 1;
      end else if (rcv_gap > 0) begin
         rsp_stall <= 1'b1;
         rcv_gap   <= rcv_gap - 1;
      end else if ($urandom_range(99) < rsp_idle_pct) begin
         rsp_stall <= 1'b1;
         rcv_gap   <= $urandom_range(16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   //--------------------------------------------------------------------------
   // Monitor: at the rising edge, feed every accepted item to the predictor and
   // compare every accepted digest with the oldest expectation.
   //--------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      digest_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            absorb_item(hash_item_type'({req_data_byte, req_has_byte, req_last}));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_digests.size() == 0) begin
               error_count++;
               $display("%0t: unexpected digest, expected none, got %08h %08h %08h %08h %08h",
                        $time, rsp_digest_word_a, rsp_digest_word_b, rsp_digest_word_c,
                        rsp_digest_word_d, rsp_digest_word_e);
            end else begin
               want = expected_digests.pop_front();
               check_word("digest_word_a", want.a, rsp_digest_word_a);
               check_word("digest_word_b", want.b, rsp_digest_word_b);
               check_word("digest_word_c", want.c, rsp_digest_word_c);
               check_word("digest_word_d", want.d, rsp_digest_word_d);
               check_word("digest_word_e", want.e, rsp_digest_word_e);
            end
         end
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d digests still expected", $time, expected_digests.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   //--------------------------------------------------------------------------
   // Stimulus
   //--------------------------------------------------------------------------
   task automatic push_item(input logic [7:0] data, input logic has, input logic fin);
      hash_item_type it;
      it.data_byte = data;
      it.has_byte  = has;
      it.last      = fin;
      pending_items.push_back(it);
      if (has || fin) begin
         queued_items++;
      end
   endtask

   // Queue one message of len bytes with random content. Scatter ignored
   // filler items through it and end either on the final byte or on a
   // separate byteless last item.
   task automatic push_message(input int len);
      int i;
      logic end_on_byte;
      end_on_byte = (len > 0) && ($urandom_range(1) == 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(99) < 6) begin
            push_item(8'($urandom_range(255)), 1'b0, 1'b0);
         end
         push_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte) begin
         push_item(8'($urandom_range(255)), 1'b0, 1'b1);
      end
   endtask

   // Mostly short messages, many right at the padding boundaries, a few long.
   function automatic int pick_length();
      int pad_edge_lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      int roll;
      roll = $urandom_range(19);
      if (roll <= 10) begin
         return $urandom_range(12);
      end else if (roll <= 16) begin
         return pad_edge_lens[$urandom_range(7)];
      end
      return $urandom_range(140);
   endfunction

   task automatic wait_queue_empty();
      while (pending_items.size() != 0 || req_valid) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_all_digests();
      wait_queue_empty();
      while (expected_digests.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int idle_pick [3] = '{0, 10, 35};
      int m;
      int n;
      restart_message();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty message, ignored filler, byte with last, extreme bytes,
      // a byteless last after bytes, the "abc" vector.
      send_idle_pct = 15;
      rsp_idle_pct  = 15;
      push_item(8'h3c, 1'b0, 1'b1);
      push_item(8'ha5, 1'b0, 1'b0);
      push_item(8'h00, 1'b1, 1'b1);
      push_item(8'hff, 1'b1, 1'b0);
      push_item(8'h7f, 1'b1, 1'b0);
      push_item(8'hff, 1'b0, 1'b0);
      push_item(8'h5a, 1'b0, 1'b1);
      push_item(8'h61, 1'b1, 1'b0);
      push_item(8'h62, 1'b1, 1'b0);
      push_item(8'h63, 1'b1, 1'b1);
      push_item(8'hff, 1'b1, 1'b1);
      push_item(8'h80, 1'b1, 1'b1);
      push_item(8'h01, 1'b0, 1'b1);
      push_item(8'h00, 1'b0, 1'b0);
      push_item(8'hff, 1'b0, 1'b1);
      wait_all_digests();

      // Back-pressure: hold the receiver off for a long stretch while the
      // sender keeps offering short messages back to back.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_trigger  = 1'b1;
      for (m = 0; m < 12; m++) begin
         push_message($urandom_range(6));
      end
      wait_queue_empty();

      // Main random part in chunks, each with its own idling mix.
      while (queued_items < ITEM_TARGET - TAIL_ITEMS) begin
         send_idle_pct = idle_pick[$urandom_range(2)];
         rsp_idle_pct  = idle_pick[$urandom_range(2)];
         for (m = 0; m < 6 && queued_items < ITEM_TARGET - TAIL_ITEMS; m++) begin
            // Now and then a run of filler items with no message content.
            if ($urandom_range(9) == 0) begin
               for (n = 0; n <= $urandom_range(3); n++) begin
                  push_item(8'($urandom_range(255)), 1'b0, 1'b0);
               end
            end
            push_message(pick_length());
         end
         wait_queue_empty();
      end

      // Tail: no idling on either side.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      n = queued_items + TAIL_ITEMS;
      while (queued_items < n) begin
         push_message(pick_length());
      end

      // Drain, then allow for anything still in flight.
      wait_all_digests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
